@@ rtl/core/vec4_pkg.sv @@
// Shared types, command codes and saturation helper for the vector unit.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package vec4_pkg;

    typedef enum logic [2:0] {
        CMD_ADD       = 3'd0,
        CMD_SUB       = 3'd1,
        CMD_SCALE     = 3'd2,
        CMD_DOT       = 3'd3,
        CMD_LENGTH    = 3'd4,
        CMD_NORMALIZE = 3'd5,
        CMD_LERP      = 3'd6,
        CMD_CROSS     = 3'd7
    } cmd_t;

    localparam int Q_SHIFT     = 16;
    localparam int SQRT_STAGES = 32;
    localparam int DVD_W       = 48;
    localparam int DIV_STAGES  = DVD_W;
    localparam int LEN_W       = 33;

    localparam logic [LEN_W-1:0] LEN_OVF = 33'h1_0000_0000;
    localparam logic signed [66:0] SAT_MAX = 67'sd2147483647;
    localparam logic signed [66:0] SAT_MIN = -67'sd2147483648;

    typedef struct packed {
        logic signed [31:0] value;
        logic               flag;
    } sat_t;

    function automatic sat_t sat32(input logic signed [66:0] v);
        sat_t s;
        priority if (v > SAT_MAX)
        begin
            s.value = 32'sh7fff_ffff;
            s.flag  = 1'b1;
        end
        else if (v < SAT_MIN)
        begin
            s.value = 32'sh8000_0000;
            s.flag  = 1'b1;
        end
        else
        begin
            s.value = v[31:0];
            s.flag  = 1'b0;
        end
        return s;
    endfunction

    // Payload carried alongside the square root pipeline.
    typedef struct packed {
        cmd_t             cmd;
        logic [3:0][31:0] a;
        logic [3:0][31:0] r;
        logic             rflag;
        sat_t             dot;
        logic             carry;
        logic             big;
    } d1_t;

    // Payload carried alongside the divider pipelines.
    typedef struct packed {
        cmd_t             cmd;
        logic [3:0][31:0] r;
        logic             rflag;
        logic [31:0]      scalar;
        logic             sflag;
        logic [3:0]       neg;
        logic             norm_ok;
    } d2_t;

endpackage

`default_nettype wire

@@ rtl/core/vec4_lane.sv @@
// One component lane: operand select and multiply, then the per-component result.
// Depends on vec4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vec4_lane (
    input  logic               clk,
    input  logic               en,
    input  vec4_pkg::cmd_t     cmd,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic signed [31:0] f,
    input  logic signed [31:0] ca0,
    input  logic signed [31:0] cb0,
    input  logic signed [31:0] ca1,
    input  logic signed [31:0] cb1,
    output logic signed [64:0] prod,
    output vec4_pkg::sat_t     res
);
    import vec4_pkg::*;

    logic signed [32:0] mx;
    logic signed [31:0] my;
    logic signed [64:0] p0_reg, p0_next;
    logic signed [63:0] p1_reg, p1_next;
    logic signed [32:0] sum_reg, sum_next;
    logic signed [32:0] dif_reg, dif_next;
    logic signed [31:0] a_reg;
    cmd_t               cmd_reg;
    sat_t               res_reg, res_next;

    always_comb
    begin
        mx = 33'(a);
        my = b;
        unique case (cmd)
            CMD_ADD, CMD_SUB, CMD_DOT:
            begin
                mx = 33'(a);
                my = b;
            end
            CMD_SCALE:
            begin
                mx = 33'(a);
                my = f;
            end
            CMD_LENGTH, CMD_NORMALIZE:
            begin
                mx = 33'(a);
                my = a;
            end
            CMD_LERP:
            begin
                mx = 33'(b) - 33'(a);
                my = f;
            end
            CMD_CROSS:
            begin
                mx = 33'(ca0);
                my = cb0;
            end
        endcase
        p0_next  = 65'(mx) * 65'(my);
        p1_next  = 64'(ca1) * 64'(cb1);
        sum_next = 33'(a) + 33'(b);
        dif_next = 33'(a) - 33'(b);
    end

    always_comb
    begin
        res_next = '0;
        unique case (cmd_reg)
            CMD_ADD:   res_next = sat32(67'(sum_reg));
            CMD_SUB:   res_next = sat32(67'(dif_reg));
            CMD_SCALE: res_next = sat32(67'(p0_reg >>> Q_SHIFT));
            CMD_LERP:  res_next = sat32(67'(a_reg) + 67'(p0_reg >>> Q_SHIFT));
            CMD_CROSS: res_next = sat32((67'(p0_reg) - 67'(p1_reg)) >>> Q_SHIFT);
            CMD_DOT, CMD_LENGTH, CMD_NORMALIZE: res_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            sum_reg <= sum_next;
            dif_reg <= dif_next;
            a_reg   <= a;
            cmd_reg <= cmd;
            res_reg <= res_next;
        end
    end

    assign prod = p0_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

@@ rtl/core/vec4_isqrt.sv @@
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// Depends on vec4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vec4_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import vec4_pkg::*;

    logic [63:0] n_reg [SQRT_STAGES];
    logic [63:0] r_reg [SQRT_STAGES];

    genvar k;
    for (k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam logic [63:0] ONE_BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] n_in, r_in, trial, n_next, r_next;

        if (k == 0)
        begin : g_first
            assign n_in = radicand;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + ONE_BIT;
            if (n_in >= trial)
            begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + ONE_BIT;
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k] <= n_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[SQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

@@ rtl/core/vec4_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for normalize.
// Depends on vec4_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vec4_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [vec4_pkg::DVD_W-1:0]    dividend,
    input  logic [vec4_pkg::LEN_W-1:0]    divisor,
    output logic [vec4_pkg::DVD_W-1:0]    quotient
);
    import vec4_pkg::*;

    logic [LEN_W-1:0] rem_reg [DIV_STAGES];
    logic [LEN_W-1:0] dsr_reg [DIV_STAGES];
    logic [DVD_W-1:0] dvd_reg [DIV_STAGES];
    logic [DVD_W-1:0] quo_reg [DIV_STAGES];

    genvar k;
    for (k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam int IDX = DVD_W - 1 - k;
        logic [LEN_W-1:0] rem_in, dsr_in, rem_next;
        logic [DVD_W-1:0] dvd_in, quo_in, quo_next;
        logic [LEN_W:0]   t, dsr_ext;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign dsr_in = divisor;
            assign dvd_in = dividend;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign dsr_in = dsr_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            t        = {rem_in, dvd_in[IDX]};
            dsr_ext  = {1'b0, dsr_in};
            ge       = (t >= dsr_ext);
            rem_next = ge ? LEN_W'(t - dsr_ext) : t[LEN_W-1:0];
            quo_next = quo_in;
            quo_next[IDX] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                dsr_reg[k] <= dsr_in;
                dvd_reg[k] <= dvd_in;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ rtl/core/vector4_alu_top.sv @@
// Four-lane Q16.16 vector unit: lanes, merge of lane products, length and normalize.
// From input accept to output valid, items pass the 2 lane stages, the 32-stage square root,
// the 48-stage divider and the output register. One item per cycle is accepted;
// the whole pipeline holds while the output register waits to be taken.
// Reset (rst_n low, asynchronous) empties the pipeline and sets the zero threshold to 1.
`timescale 1ns / 1ps
`default_nettype none

module vector4_alu_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // ax, ay, az, aw, bx, by, bz, bw, factor
    input  logic [287:0] s_axis_tdata,
    // command
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rx, ry, rz, rw, scalar
    output logic [159:0] m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data
);
    import vec4_pkg::*;

    localparam int PIPE = 2 + SQRT_STAGES + DIV_STAGES;

    logic               en;
    cmd_t               cmd_in;
    logic signed [31:0] a_in [4];
    logic signed [31:0] b_in [4];
    logic signed [31:0] f_in;
    logic signed [31:0] ca0 [4];
    logic signed [31:0] cb0 [4];
    logic signed [31:0] ca1 [4];
    logic signed [31:0] cb1 [4];
    logic signed [64:0] prod [4];
    sat_t               lres [4];

    logic [30:0]        thr_reg;
    logic [PIPE-1:0]    v_reg;
    logic               out_valid_reg;

    cmd_t               cmd1_reg, cmd2_reg;
    logic [3:0][31:0]   a1_reg, a2_reg;
    sat_t               dot2_reg, dot_next;
    logic [64:0]        ss2_reg;
    logic signed [66:0] psum;

    d1_t                d1_reg [SQRT_STAGES];
    d1_t                d1_next, d1_last;
    d2_t                d2_reg [DIV_STAGES];
    d2_t                d2_next, d2_last;

    logic [31:0]        root;
    logic [LEN_W-1:0]   len;
    logic [DVD_W-1:0]   dividend [4];
    logic [DVD_W-1:0]   quo [4];

    logic [31:0]        out_r_reg [4];
    logic [31:0]        out_r_next [4];
    logic [31:0]        out_s_reg;
    logic               out_f_reg, out_f_next;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign cmd_in        = cmd_t'(s_axis_tuser);
    assign f_in          = s_axis_tdata[256 +: 32];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            a_in[i] = s_axis_tdata[32*i +: 32];
            b_in[i] = s_axis_tdata[128 + 32*i +: 32];
        end
        // Cross operands: x = ay*bz - az*by, y = az*bx - ax*bz, z = ax*by - ay*bx.
        ca0[0] = a_in[1]; cb0[0] = b_in[2]; ca1[0] = a_in[2]; cb1[0] = b_in[1];
        ca0[1] = a_in[2]; cb0[1] = b_in[0]; ca1[1] = a_in[0]; cb1[1] = b_in[2];
        ca0[2] = a_in[0]; cb0[2] = b_in[1]; ca1[2] = a_in[1]; cb1[2] = b_in[0];
        ca0[3] = '0;      cb0[3] = '0;      ca1[3] = '0;      cb1[3] = '0;
    end

    genvar g;
    for (g = 0; g < 4; g++)
    begin : g_lane
        vec4_lane u_lane (
            .clk  (clk),
            .en   (en),
            .cmd  (cmd_in),
            .a    (a_in[g]),
            .b    (b_in[g]),
            .f    (f_in),
            .ca0  (ca0[g]),
            .cb0  (cb0[g]),
            .ca1  (ca1[g]),
            .cb1  (cb1[g]),
            .prod (prod[g]),
            .res  (lres[g])
        );
    end

    // Merge: the lane products sum to the dot product, or to the sum of squares.
    always_comb
    begin
        psum     = 67'(prod[0]) + 67'(prod[1]) + 67'(prod[2]) + 67'(prod[3]);
        dot_next = sat32(psum >>> Q_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg <= cmd_in;
            for (int i = 0; i < 4; i++)
            begin
                a1_reg[i] <= a_in[i];
            end
            cmd2_reg <= cmd1_reg;
            a2_reg   <= a1_reg;
            dot2_reg <= dot_next;
            ss2_reg  <= psum[64:0];
        end
    end

    vec4_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (ss2_reg[63:0]),
        .root     (root)
    );

    always_comb
    begin
        d1_next.cmd   = cmd2_reg;
        d1_next.a     = a2_reg;
        d1_next.rflag = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            d1_next.r[i]  = lres[i].value;
            d1_next.rflag = d1_next.rflag | lres[i].flag;
        end
        d1_next.dot   = dot2_reg;
        d1_next.carry = ss2_reg[64];
        d1_next.big   = ss2_reg[64] | ss2_reg[63] | ss2_reg[62];
    end

    assign d1_last = d1_reg[SQRT_STAGES-1];

    always_comb
    begin
        len = d1_last.carry ? LEN_OVF : {1'b0, root};
        d2_next.cmd     = d1_last.cmd;
        d2_next.r       = d1_last.r;
        d2_next.rflag   = d1_last.rflag;
        d2_next.norm_ok = (len != '0) && (len >= LEN_W'(thr_reg));
        for (int i = 0; i < 4; i++)
        begin
            d2_next.neg[i] = d1_last.a[i][31];
            dividend[i]    = {(d1_last.a[i][31] ? -d1_last.a[i] : d1_last.a[i]),
                              {Q_SHIFT{1'b0}}};
        end
        priority if (d1_last.cmd == CMD_DOT)
        begin
            d2_next.scalar = d1_last.dot.value;
            d2_next.sflag  = d1_last.dot.flag;
        end
        else if (d1_last.cmd == CMD_LENGTH)
        begin
            d2_next.scalar = d1_last.big ? 32'h7fff_ffff : root;
            d2_next.sflag  = d1_last.big;
        end
        else
        begin
            d2_next.scalar = '0;
            d2_next.sflag  = 1'b0;
        end
    end

    for (g = 0; g < 4; g++)
    begin : g_div
        vec4_div u_div (
            .clk      (clk),
            .en       (en),
            .dividend (dividend[g]),
            .divisor  (len),
            .quotient (quo[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg[0] <= d1_next;
            for (int k = 1; k < SQRT_STAGES; k++)
            begin
                d1_reg[k] <= d1_reg[k-1];
            end
            d2_reg[0] <= d2_next;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                d2_reg[k] <= d2_reg[k-1];
            end
        end
    end

    assign d2_last = d2_reg[DIV_STAGES-1];

    always_comb
    begin
        logic signed [66:0] qs;
        sat_t               nres;
        out_f_next = d2_last.rflag | d2_last.sflag;
        for (int i = 0; i < 4; i++)
        begin
            qs   = 67'({{(67 - DVD_W){1'b0}}, quo[i]});
            nres = d2_last.norm_ok ? sat32(d2_last.neg[i] ? -qs : qs) : '0;
            if (d2_last.cmd == CMD_NORMALIZE)
            begin
                out_r_next[i] = nres.value;
                out_f_next    = out_f_next | nres.flag;
            end
            else
            begin
                out_r_next[i] = d2_last.r[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                out_r_reg[i] <= out_r_next[i];
            end
            out_s_reg <= d2_last.scalar;
            out_f_reg <= out_f_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= 31'd1;
        end
        else
        begin
            if (en)
            begin
                v_reg         <= {v_reg[PIPE-2:0], s_axis_tvalid};
                out_valid_reg <= v_reg[PIPE-1];
            end
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_s_reg, out_r_reg[3], out_r_reg[2], out_r_reg[1], out_r_reg[0]};
    assign m_axis_tuser  = out_f_reg;

endmodule

`default_nettype wire

@@ test/vector4_alu_top_tb.sv @@
// Self-checking testbench for vector4_alu_top: random and directed Q16.16 vector commands.
// Results are predicted locally and compared in order; depends on vec4_pkg and the RTL top.
`timescale 1ns / 1ps

module vector4_alu_top_tb;
    import vec4_pkg::*;

    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] a [4];
        logic signed [31:0] b [4];
        logic signed [31:0] factor;
    } vec_op_t;

    typedef struct {
        logic signed [31:0] r [4];
        logic signed [31:0] scalar;
        logic               saturated;
    } vec_res_t;

    function automatic logic signed [31:0] clamp32(input logic signed [66:0] v,
                                                   inout logic flag);
        if (v > 67'sd2147483647)
        begin
            flag = 1'b1;
            return 32'sh7fff_ffff;
        end
        if (v < -67'sd2147483648)
        begin
            flag = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic vec_res_t compute_vec(input vec_op_t op, input logic [30:0] thr);
        vec_res_t e;
        logic signed [66:0] a [4];
        logic signed [66:0] b [4];
        logic signed [66:0] f, acc, t;
        logic [64:0] sq;
        logic [63:0] len, m, q, root;
        logic flag;
        flag = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            a[i] = op.a[i];
            b[i] = op.b[i];
            e.r[i] = 0;
        end
        f = op.factor;
        e.scalar = 0;
        sq = 0;
        for (int i = 0; i < 4; i++)
        begin
            m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
            sq = sq + 65'(m * m);
        end
        case (op.cmd)
            CMD_ADD:
                for (int i = 0; i < 4; i++) e.r[i] = clamp32(a[i] + b[i], flag);
            CMD_SUB:
                for (int i = 0; i < 4; i++) e.r[i] = clamp32(a[i] - b[i], flag);
            CMD_SCALE:
                for (int i = 0; i < 4; i++) e.r[i] = clamp32((a[i] * f) >>> 16, flag);
            CMD_DOT:
            begin
                acc = 0;
                for (int i = 0; i < 4; i++) acc = acc + a[i] * b[i];
                e.scalar = clamp32(acc >>> 16, flag);
            end
            CMD_LENGTH:
            begin
                if (sq >= (65'd1 << 62))
                begin
                    flag = 1'b1;
                    e.scalar = 32'sh7fff_ffff;
                end
                else
                begin
                    root = floor_sqrt(sq[63:0]);
                    e.scalar = root[31:0];
                end
            end
            CMD_NORMALIZE:
            begin
                len = sq[64] ? (64'd1 << 32) : floor_sqrt(sq[63:0]);
                if (len != 0 && len >= thr)
                    for (int i = 0; i < 4; i++)
                    begin
                        m = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
                        q = (m << 16) / len;
                        t = {3'b0, q};
                        e.r[i] = clamp32((a[i] < 0) ? -t : t, flag);
                    end
            end
            CMD_LERP:
                for (int i = 0; i < 4; i++)
                    e.r[i] = clamp32(a[i] + (((b[i] - a[i]) * f) >>> 16), flag);
            default:
            begin
                e.r[0] = clamp32((a[1] * b[2] - a[2] * b[1]) >>> 16, flag);
                e.r[1] = clamp32((a[2] * b[0] - a[0] * b[2]) >>> 16, flag);
                e.r[2] = clamp32((a[0] * b[1] - a[1] * b[0]) >>> 16, flag);
            end
        endcase
        e.saturated = flag;
        return e;
    endfunction

    class vec_scoreboard;
        vec_res_t pending [$];
        int errors;

        function void note_input(vec_op_t op, logic [30:0] thr);
            pending.push_back(compute_vec(op, thr));
        endfunction

        function void check_result(vec_res_t got);
            vec_res_t want;
            bit bad;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result item rx=%h", got.r[0]);
                return;
            end
            want = pending.pop_front();
            bad = (got.scalar !== want.scalar) || (got.saturated !== want.saturated);
            for (int i = 0; i < 4; i++)
                if (got.r[i] !== want.r[i])
                    bad = 1;
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                    $display("Mismatch: expected %h %h %h %h s=%h f=%b got %h %h %h %h s=%h f=%b",
                             want.r[0], want.r[1], want.r[2], want.r[3], want.scalar,
                             want.saturated, got.r[0], got.r[1], got.r[2], got.r[3],
                             got.scalar, got.saturated);
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [287:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [30:0]  cfg_data = '0;

    vector4_alu_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    vec_scoreboard sb = new();
    logic [30:0] threshold = 31'd1;
    vec_op_t     cur_op;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);

    // Inputs are stable at the falling edge, so items seen here are taken at the next rise.
    always @(negedge clk)
    begin
        vec_res_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(cur_op, threshold);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            for (int i = 0; i < 4; i++)
                got.r[i] = m_axis_tdata[32*i +: 32];
            got.scalar = m_axis_tdata[159:128];
            got.saturated = m_axis_tuser[0];
            sb.check_result(got);
        end
    end

    task automatic send_op(input vec_op_t op);
        bit taken;
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        cur_op = op;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op.cmd;
        s_axis_tdata <= {op.factor, op.b[3], op.b[2], op.b[1], op.b[0],
                         op.a[3], op.a[2], op.a[1], op.a[0]};
        do
        begin
            @(negedge clk);
            taken = s_axis_tvalid && s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [30:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_valid && cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        threshold = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_q;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7fff_ffff - $urandom_range(0, 3);
            2: return 32'sh8000_0000 + $urandom_range(0, 3);
            3: return $urandom_range(0, 32'h0001_ffff) - 32'sh0001_0000;
            default: return $urandom_range(0, 32'h00ff_ffff) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic vec_op_t rand_op;
        vec_op_t op;
        op.cmd = cmd_t'($urandom_range(0, 7));
        for (int i = 0; i < 4; i++)
        begin
            op.a[i] = rand_q();
            op.b[i] = rand_q();
        end
        op.factor = rand_q();
        return op;
    endfunction

    function automatic vec_op_t fill_op(input cmd_t c, input logic signed [31:0] av,
                                        input logic signed [31:0] bv,
                                        input logic signed [31:0] fv);
        vec_op_t op;
        op.cmd = c;
        for (int i = 0; i < 4; i++)
        begin
            op.a[i] = av;
            op.b[i] = bv;
        end
        op.factor = fv;
        return op;
    endfunction

    initial
    begin
        vec_op_t op;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes for every command, zero-length normalize, length overflow.
        for (int c = 0; c < 8; c++)
        begin
            send_op(fill_op(cmd_t'(c), 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000));
            send_op(fill_op(cmd_t'(c), 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff));
        end
        send_op(fill_op(CMD_NORMALIZE, 0, 0, 0));
        send_op(fill_op(CMD_NORMALIZE, 32'sh0000_0001, 0, 0));
        send_op(fill_op(CMD_LENGTH, 32'sh4000_0000, 0, 0));
        send_op(fill_op(CMD_LERP, 32'sh0001_0000, 32'sh0003_0000, 32'sh0000_8000));
        send_op(fill_op(CMD_SCALE, 32'shffff_ffff, 0, 32'sh0000_0001));
        op = fill_op(CMD_CROSS, 0, 0, 0);
        op.a[0] = 32'sh0001_0000;
        op.b[1] = 32'sh0001_0000;
        op.a[3] = 32'sh7fff_ffff;
        send_op(op);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle = 7;
                    recv_idle = 58;
                    write_threshold(31'd0);
                end
                1:
                begin
                    send_idle = 58;
                    recv_idle = 7;
                    write_threshold(31'h7fff_ffff);
                end
                default:
                begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_threshold(31'($urandom_range(0, 32'h0004_0000)));
                end
            endcase
            for (int n = 0; n < 450; n++)
            begin
                send_op(rand_op());
                // Hold off the sender once until the pipeline has emptied.
                if (phase == 0 && n == 200)
                    drain();
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
